// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// clocked on clk; ASSERT_PROP is held off while rst is high
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_PROP(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== src/stt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_pkg
// command codes, result codes and controller/datapath handshake types
// ----------------------------------------------------------------------------
package stt_pkg;

  typedef enum logic [2:0] {
    CMD_REGISTER = 3'd0,
    CMD_START    = 3'd1,
    CMD_STOP     = 3'd2,
    CMD_PAUSE    = 3'd3,
    CMD_RESUME   = 3'd4,
    CMD_TICK     = 3'd5,
    CMD_POLL     = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_REPLY     = 2'd0,
    KIND_EXPIRY    = 2'd1,
    KIND_TICK_DONE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FAIL    = 2'd1,
    STAT_NO_SLOT = 2'd2
  } status_t;

  typedef struct packed {
    logic exec;
    logic walk_clr;
    logic rd_en;
    logic rd_next;
    logic eval_en;
    logic emit_end;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic walk_last;
    logic need_event;
  } dp_stat_t;

endpackage

// ===== src/stt_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_in_if
// command channel: valid/ready with one command item
// ----------------------------------------------------------------------------
interface stt_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [3:0]  slot_id;
  logic        mode;
  logic [15:0] delay;
  logic        has_handler;

  modport source (output valid, command, slot_id, mode, delay, has_handler, input ready);
  modport sink (input valid, command, slot_id, mode, delay, has_handler, output ready);
endinterface

// ===== src/stt_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_out_if
// result channel: valid/ready with one result item
// ----------------------------------------------------------------------------
interface stt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [1:0] status;
  logic [3:0] slot_id_res;
  logic       update_seen;
  logic       last;

  modport source (output valid, kind, status, slot_id_res, update_seen, last, input ready);
  modport sink (input valid, kind, status, slot_id_res, update_seen, last, output ready);
endinterface

// ===== src/software_timer_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// software_timer_table
// table of software timers driven by register/start/stop/pause/resume/poll
// commands, with a tick that walks all slots and reports expiries
// ----------------------------------------------------------------------------
//   port  | role   | item
//   ------+--------+-----------------------------------------------------------
//   req   | sink   | command, slot_id, mode, delay, has_handler
//   rsp   | source | kind, status, slot_id_res, update_seen, last
//
// a non-tick command is taken while the result register is free; its reply
// sits in the result register at the next edge, so commands can follow back
// to back while results are taken. a tick walks the slots one at a time,
// set by the single read port of the delay and count memories.
// no clearing pass at reset; untouched entries read as zero.
// a full result register stalls the walk on the slot whose expiry is waiting.
// ----------------------------------------------------------------------------
module software_timer_table #(
  parameter int NUM_TIMERS = 16
) (
  input logic      clk,
  input logic      rst,
  stt_in_if.sink   req,
  stt_out_if.source rsp
);
  import stt_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  stt_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req.valid),
    .req_command (req.command),
    .req_ready   (req.ready),
    .cmd         (cmd),
    .stat        (stat)
  );

  stt_datapath #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .command     (req.command),
    .slot_id     (req.slot_id),
    .mode        (req.mode),
    .delay       (req.delay),
    .has_handler (req.has_handler),
    .out_ready   (rsp.ready),
    .out_valid   (rsp.valid),
    .kind        (rsp.kind),
    .status      (rsp.status),
    .slot_id_res (rsp.slot_id_res),
    .update_seen (rsp.update_seen),
    .last        (rsp.last)
  );

endmodule

// ===== src/stt_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_datapath
// slot state flops, delay/count memories, slot walk counter, result register
// ----------------------------------------------------------------------------
module stt_datapath #(
  parameter int NUM_TIMERS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  stt_pkg::ctrl_cmd_t cmd,
  output stt_pkg::dp_stat_t  stat,
  input  logic [2:0]        command,
  input  logic [3:0]        slot_id,
  input  logic              mode,
  input  logic [15:0]       delay,
  input  logic              has_handler,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [1:0]        kind,
  output logic [1:0]        status,
  output logic [3:0]        slot_id_res,
  output logic              update_seen,
  output logic              last
);
  import stt_pkg::*;

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  typedef logic [IW-1:0] idx_t;

  typedef struct packed {
    logic        periodic;
    logic        handler;
    logic [15:0] target;
  } cfg_t;

  // per-slot flags; a slot is inactive when neither act nor psd is set
  logic [NUM_TIMERS-1:0] taken, act, psd, upd_flag, cfg_valid, cnt_valid;

  cfg_t        cfg_mem [NUM_TIMERS];
  logic [15:0] cnt_mem [NUM_TIMERS];

  cfg_t        rd_cfg;
  logic [15:0] rd_cnt;
  logic        rd_cfg_ok, rd_cnt_ok;

  idx_t    walk, cid, free_idx, rd_addr, cnt_waddr;
  logic    free_found, id_ok;
  status_t rep_status;
  logic [3:0] rep_id;
  logic    rep_seen;
  logic    cmd_ok;

  cfg_t        cur_cfg;
  logic [15:0] cur_cnt, cnt_inc, cnt_wdata;
  logic        expire, slot_active, cnt_we, out_load;

  assign id_ok = 32'(slot_id) < NUM_TIMERS;
  assign cid   = IW'(slot_id);

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int s = NUM_TIMERS - 1; s >= 0; s--) begin
      if (!taken[s]) begin
        free_found = 1'b1;
        free_idx   = IW'(s);
      end
    end
  end

  always_comb begin
    rep_status = STAT_FAIL;
    rep_id     = '0;
    rep_seen   = 1'b0;
    case (command)
      CMD_REGISTER: begin
        if (free_found) begin
          rep_status = STAT_OK;
          rep_id     = 4'(free_idx);
        end else begin
          rep_status = STAT_NO_SLOT;
        end
      end
      CMD_START:  if (id_ok && taken[cid] && !act[cid]) rep_status = STAT_OK;
      CMD_STOP:   if (id_ok && (act[cid] || psd[cid])) rep_status = STAT_OK;
      CMD_PAUSE:  if (id_ok && !psd[cid]) rep_status = STAT_OK;
      CMD_RESUME: if (id_ok && psd[cid]) rep_status = STAT_OK;
      CMD_POLL: begin
        if (id_ok) begin
          rep_status = STAT_OK;
          rep_seen   = upd_flag[cid];
        end
      end
      default: ;
    endcase
  end

  assign cmd_ok = cmd.exec && (rep_status == STAT_OK);

  // slot under evaluation during a tick; never-written entries read as zero
  assign cur_cfg     = rd_cfg_ok ? rd_cfg : '0;
  assign cur_cnt     = rd_cnt_ok ? rd_cnt : '0;
  assign cnt_inc     = cur_cnt + 16'd1;
  assign expire      = cnt_inc >= cur_cfg.target;
  assign slot_active = act[walk];

  assign stat.need_event = slot_active && expire && cur_cfg.handler;
  assign stat.walk_last  = walk == IW'(NUM_TIMERS - 1);
  assign stat.out_free   = !out_valid || out_ready;

  assign rd_addr = cmd.rd_next ? walk + IW'(1) : walk;

  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = walk;
    cnt_wdata = (expire && cur_cfg.periodic) ? 16'd0 : cnt_inc;
    if (cmd_ok && command == CMD_START) begin
      cnt_we    = 1'b1;
      cnt_waddr = cid;
      cnt_wdata = 16'd0;
    end else if (cmd.eval_en && slot_active) begin
      cnt_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      taken     <= '0;
      act       <= '0;
      psd       <= '0;
      upd_flag  <= '0;
      cfg_valid <= '0;
      cnt_valid <= '0;
    end else begin
      if (cmd_ok) begin
        case (command)
          CMD_REGISTER: begin
            taken[free_idx]     <= 1'b1;
            upd_flag[free_idx]  <= 1'b0;
            cfg_valid[free_idx] <= 1'b1;
          end
          CMD_START: begin
            act[cid]       <= 1'b1;
            psd[cid]       <= 1'b0;
            cnt_valid[cid] <= 1'b1;
          end
          CMD_STOP: begin
            act[cid]   <= 1'b0;
            psd[cid]   <= 1'b0;
            taken[cid] <= 1'b0;
          end
          CMD_PAUSE: begin
            act[cid] <= 1'b0;
            psd[cid] <= 1'b1;
          end
          CMD_RESUME: begin
            act[cid] <= 1'b1;
            psd[cid] <= 1'b0;
          end
          CMD_POLL: upd_flag[cid] <= 1'b0;
          default: ;
        endcase
      end
      if (cmd.eval_en && slot_active) begin
        cnt_valid[walk] <= 1'b1;
        if (expire && !cur_cfg.periodic) act[walk] <= 1'b0;
        if (expire && !cur_cfg.handler) upd_flag[walk] <= 1'b1;
      end
    end
  end

  // slot memories, one write and one registered read each
  always_ff @(posedge clk) begin
    if (cmd_ok && command == CMD_REGISTER) begin
      cfg_mem[free_idx] <= '{periodic: mode, handler: has_handler, target: delay};
    end
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    if (cmd.rd_en) begin
      rd_cfg    <= cfg_mem[rd_addr];
      rd_cnt    <= cnt_mem[rd_addr];
      rd_cfg_ok <= cfg_valid[rd_addr];
      rd_cnt_ok <= cnt_valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk <= '0;
    end else if (cmd.walk_clr) begin
      walk <= '0;
    end else if (cmd.eval_en && !stat.walk_last) begin
      walk <= walk + IW'(1);
    end
  end

  // result register
  assign out_load = cmd.exec || (cmd.eval_en && stat.need_event) || cmd.emit_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      kind        <= KIND_REPLY;
      status      <= rep_status;
      slot_id_res <= rep_id;
      update_seen <= rep_seen;
      last        <= 1'b1;
    end else if (cmd.eval_en && stat.need_event) begin
      kind        <= KIND_EXPIRY;
      status      <= STAT_OK;
      slot_id_res <= 4'(walk);
      update_seen <= 1'b0;
      last        <= 1'b0;
    end else if (cmd.emit_end) begin
      kind        <= KIND_TICK_DONE;
      status      <= STAT_OK;
      slot_id_res <= '0;
      update_seen <= 1'b0;
      last        <= 1'b1;
    end
  end

endmodule

// ===== src/stt_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// stt_ctrl
// command acceptance and tick walk sequencing
// ----------------------------------------------------------------------------
module stt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic [2:0]         req_command,
  output logic               req_ready,
  output stt_pkg::ctrl_cmd_t cmd,
  input  stt_pkg::dp_stat_t  stat
);
  import stt_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE      = 4'b0001,
    ST_TICK_RD   = 4'b0010,
    ST_TICK_EVAL = 4'b0100,
    ST_TICK_END  = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        req_ready = stat.out_free;
        if (req_valid && stat.out_free) begin
          if (req_command == CMD_TICK) begin
            cmd.walk_clr = 1'b1;
            state_next   = ST_TICK_RD;
          end else begin
            cmd.exec = 1'b1;
          end
        end
      end
      ST_TICK_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_TICK_EVAL;
      end
      ST_TICK_EVAL: begin
        // hold the slot while an expiry item has nowhere to go
        if (!stat.need_event || stat.out_free) begin
          cmd.eval_en = 1'b1;
          if (stat.walk_last) begin
            state_next = ST_TICK_END;
          end else begin
            cmd.rd_en   = 1'b1;
            cmd.rd_next = 1'b1;
          end
        end
      end
      ST_TICK_END: begin
        if (stat.out_free) begin
          cmd.emit_end = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `ASSERT_PROP(a_event_has_room, (cmd.eval_en && stat.need_event) |-> stat.out_free, "expiry item overwrites pending result")
  `ASSERT_PROP(a_end_has_room, cmd.emit_end |-> stat.out_free, "tick done item overwrites pending result")
  `ASSERT_PROP(a_walk_stops, (cmd.eval_en && stat.walk_last) |=> !cmd.eval_en, "slot walk runs past last slot")
  `ASSERT_PROP(a_no_accept_in_tick, req_ready |-> !(cmd.eval_en || cmd.rd_en), "item accepted during tick walk")
  `ASSERT_ALWAYS(a_reset_idle, rst |=> state == ST_IDLE, "controller not idle after reset")

endmodule

// ===== tb/timer_table_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_table_checker
// watches the command and result channels of the timer table, keeps its own
// copy of the slot table, works out the items each accepted command must
// produce and compares every accepted result item with the oldest one due
// ----------------------------------------------------------------------------
module timer_table_checker #(
  parameter int NUM_SLOTS = 16
) (
  input  logic clk,
  input  logic rst,
  stt_in_if    req,
  stt_out_if   rsp,
  output int   fail_count,
  output int   pending_results
);
  import stt_pkg::*;

  localparam int MAX_PRINTED = 40;

  typedef enum logic [1:0] {
    RUN_IDLE   = 2'd0,
    RUN_ACTIVE = 2'd1,
    RUN_PAUSED = 2'd2
  } timer_run_t;

  typedef struct {
    kind_t      kind;
    status_t    status;
    logic [3:0] slot;
    logic       seen;
    logic       last;
  } timer_result_t;

  logic          slot_taken   [NUM_SLOTS];
  timer_run_t    run_state    [NUM_SLOTS];
  logic          periodic     [NUM_SLOTS];
  logic          handler      [NUM_SLOTS];
  logic [15:0]   target_delay [NUM_SLOTS];
  logic [15:0]   tick_count   [NUM_SLOTS];
  logic          update_flag  [NUM_SLOTS];
  timer_result_t results_due  [$];

  initial begin
    fail_count      = 0;
    pending_results = 0;
  end

  task automatic report_mismatch(input string msg);
    if (fail_count < MAX_PRINTED) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
    fail_count++;
  endtask

  // updates the slot table for one command and queues the items it causes
  task automatic run_timer_command(input logic [2:0] cmd, input logic [3:0] id,
                                   input logic md, input logic [15:0] dly,
                                   input logic hh);
    status_t       st;
    logic [3:0]    slot;
    logic          seen;
    bit            found;
    bit            ok;
    timer_result_t r;
    st    = STAT_FAIL;
    slot  = '0;
    seen  = 1'b0;
    found = 1'b0;
    ok    = 32'(id) < NUM_SLOTS;
    case (cmd)
      CMD_REGISTER: begin
        st = STAT_NO_SLOT;
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (!found && !slot_taken[s]) begin
            found           = 1'b1;
            periodic[s]     = md;
            target_delay[s] = dly;
            handler[s]      = hh;
            slot_taken[s]   = 1'b1;
            update_flag[s]  = 1'b0;
            st              = STAT_OK;
            slot            = 4'(s);
          end
        end
      end
      CMD_START: begin
        if (ok && slot_taken[id] && run_state[id] != RUN_ACTIVE) begin
          run_state[id]  = RUN_ACTIVE;
          tick_count[id] = '0;
          st             = STAT_OK;
        end
      end
      CMD_STOP: begin
        if (ok && run_state[id] != RUN_IDLE) begin
          run_state[id]  = RUN_IDLE;
          slot_taken[id] = 1'b0;
          st             = STAT_OK;
        end
      end
      CMD_PAUSE: begin
        if (ok && run_state[id] != RUN_PAUSED) begin
          run_state[id] = RUN_PAUSED;
          st            = STAT_OK;
        end
      end
      CMD_RESUME: begin
        if (ok && run_state[id] == RUN_PAUSED) begin
          run_state[id] = RUN_ACTIVE;
          st            = STAT_OK;
        end
      end
      CMD_POLL: begin
        if (ok) begin
          seen            = update_flag[id];
          update_flag[id] = 1'b0;
          st              = STAT_OK;
        end
      end
      default: ;
    endcase

    if (cmd == CMD_TICK) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        if (run_state[s] == RUN_ACTIVE) begin
          tick_count[s] = tick_count[s] + 16'd1;
          if (tick_count[s] >= target_delay[s]) begin
            if (periodic[s]) begin
              tick_count[s] = '0;
            end else begin
              run_state[s] = RUN_IDLE;
            end
            if (handler[s]) begin
              r = '{KIND_EXPIRY, STAT_OK, 4'(s), 1'b0, 1'b0};
              results_due.push_back(r);
            end else begin
              update_flag[s] = 1'b1;
            end
          end
        end
      end
      r = '{KIND_TICK_DONE, STAT_OK, 4'd0, 1'b0, 1'b1};
    end else begin
      r = '{KIND_REPLY, st, slot, seen, 1'b1};
    end
    results_due.push_back(r);
  endtask

  always @(posedge clk) begin : watch_channels
    timer_result_t want;
    if (rst) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        slot_taken[s]   = 1'b0;
        run_state[s]    = RUN_IDLE;
        periodic[s]     = 1'b0;
        handler[s]      = 1'b0;
        target_delay[s] = '0;
        tick_count[s]   = '0;
        update_flag[s]  = 1'b0;
      end
      results_due.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("result with none due: kind %0d status %0d id %0d",
                                    rsp.kind, rsp.status, rsp.slot_id_res));
        end else begin
          want = results_due.pop_front();
          if (rsp.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", rsp.kind, want.kind));
          if (rsp.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d (kind %0d)",
                                      rsp.status, want.status, want.kind));
          if (rsp.slot_id_res !== want.slot)
            report_mismatch($sformatf("slot_id_res %0d, want %0d (kind %0d)",
                                      rsp.slot_id_res, want.slot, want.kind));
          if (rsp.update_seen !== want.seen)
            report_mismatch($sformatf("update_seen %0d, want %0d",
                                      rsp.update_seen, want.seen));
          if (rsp.last !== want.last)
            report_mismatch($sformatf("last %0d, want %0d (kind %0d)",
                                      rsp.last, want.last, want.kind));
        end
      end
      if (req.valid && req.ready) begin
        run_timer_command(req.command, req.slot_id, req.mode, req.delay, req.has_handler);
      end
    end
    pending_results = results_due.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives the timer table with a directed command sequence, a back-pressure
// phase that fills the table, then random episodes of register / start /
// tick / poll traffic with random gaps and stalls; the checker judges results
// ----------------------------------------------------------------------------
module tb_top;
  import stt_pkg::*;

  localparam logic [2:0] CMD_UNDEFINED = 3'd7;
  localparam int ITEM_TARGET  = 450;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 40;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending_results;
  int   items_sent;
  int   idle_cycles;
  bit   no_gaps;
  bit   hold_req;
  int   stall_left;
  int   rx_mode;
  int   rx_phase;

  stt_in_if  req_if ();
  stt_out_if rsp_if ();

  software_timer_table u_top (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  timer_table_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .req             (req_if),
    .rsp             (rsp_if),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // mostly short delays so timers expire often, now and then a full-width one
  function automatic logic [15:0] pick_delay();
    if ($urandom_range(0, 99) < 85) return 16'($urandom_range(0, 4));
    return 16'($urandom);
  endfunction

  task automatic send_cmd(input logic [2:0] cmd, input logic [3:0] id,
                          input logic md = 1'b0, input logic [15:0] dly = '0,
                          input logic hh = 1'b0);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.command     <= cmd;
    req_if.slot_id     <= id;
    req_if.mode        <= md;
    req_if.delay       <= dly;
    req_if.has_handler <= hh;
    @(posedge clk);
    while (req_if.ready !== 1'b1) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    req_if.valid <= 1'b0;
    wait (pending_results == 0);
  endtask

  // free slots 0..k-1 first so the registers land on known ids
  task automatic run_episode();
    int         k;
    int         op;
    logic [3:0] id;
    k       = $urandom_range(1, 6);
    no_gaps = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < k; i++) begin
      send_cmd(CMD_PAUSE, 4'(i));
      send_cmd(CMD_STOP, 4'(i));
    end
    for (int i = 0; i < k; i++) begin
      send_cmd(CMD_REGISTER, 4'($urandom), 1'($urandom), pick_delay(), 1'($urandom));
    end
    for (int i = 0; i < k; i++) begin
      send_cmd(CMD_START, 4'(i));
    end
    repeat ($urandom_range(8, 24)) begin
      id = 4'($urandom_range(0, k - 1));
      op = $urandom_range(0, 99);
      if (op < 40) send_cmd(CMD_TICK, 4'($urandom));
      else if (op < 55) send_cmd(CMD_POLL, id);
      else if (op < 63) send_cmd(CMD_PAUSE, id);
      else if (op < 71) send_cmd(CMD_RESUME, id);
      else if (op < 79) send_cmd(CMD_START, id);
      else if (op < 85) send_cmd(CMD_STOP, id);
      else if (op < 91) send_cmd(CMD_REGISTER, id, 1'($urandom), pick_delay(), 1'($urandom));
      else send_cmd(3'($urandom), 4'($urandom), 1'($urandom), 16'($urandom), 1'($urandom));
    end
  endtask

  // result side: random stalls, rare long ones, and the long hold on request
  initial begin
    rsp_if.ready = 1'b0;
    stall_left   = 0;
    rx_mode      = 0;
    rx_phase     = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        if (rx_phase == 0) rx_mode = $urandom_range(0, 2);
        rx_phase = (rx_phase + 1) % 64;
        if (stall_left > 0) begin
          stall_left--;
          rsp_if.ready <= 1'b0;
        end else if ($urandom_range(0, 299) == 0) begin
          stall_left = $urandom_range(20, 80);
          rsp_if.ready <= 1'b0;
        end else begin
          case (rx_mode)
            0:       rsp_if.ready <= 1'b1;
            1:       rsp_if.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_if.ready <= ($urandom_range(0, 9) < 3);
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst                = 1'b1;
    hold_req           = 1'b0;
    no_gaps            = 1'b0;
    items_sent         = 0;
    req_if.valid       = 1'b0;
    req_if.command     = '0;
    req_if.slot_id     = '0;
    req_if.mode        = 1'b0;
    req_if.delay       = '0;
    req_if.has_handler = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: one-shot, periodic, flag and event paths, failing replies
    send_cmd(CMD_REGISTER, 4'd0, 1'b0, 16'd0, 1'b1);
    send_cmd(CMD_REGISTER, 4'd0, 1'b1, 16'd1, 1'b0);
    send_cmd(CMD_REGISTER, 4'd0, 1'b1, 16'hFFFF, 1'b1);
    send_cmd(CMD_REGISTER, 4'd0, 1'b1, 16'd2, 1'b1);
    send_cmd(CMD_START, 4'd0);
    send_cmd(CMD_START, 4'd1);
    send_cmd(CMD_START, 4'd2);
    send_cmd(CMD_START, 4'd3);
    send_cmd(CMD_START, 4'd0);
    send_cmd(CMD_START, 4'd15);
    send_cmd(CMD_TICK, 4'd0);
    send_cmd(CMD_TICK, 4'd0);
    send_cmd(CMD_POLL, 4'd1);
    send_cmd(CMD_POLL, 4'd1);
    // expired one-shot: still taken, stop fails but start works again
    send_cmd(CMD_STOP, 4'd0);
    send_cmd(CMD_START, 4'd0);
    send_cmd(CMD_PAUSE, 4'd2);
    send_cmd(CMD_PAUSE, 4'd2);
    send_cmd(CMD_TICK, 4'd0);
    send_cmd(CMD_RESUME, 4'd2);
    send_cmd(CMD_RESUME, 4'd2);
    send_cmd(CMD_STOP, 4'd2);
    send_cmd(CMD_STOP, 4'd2);
    send_cmd(CMD_UNDEFINED, 4'd15, 1'b1, 16'hFFFF, 1'b1);
    send_cmd(CMD_PAUSE, 4'd5);
    wait_all_results();

    // results held off while commands keep coming; table runs out of slots
    hold_req = 1'b1;
    no_gaps  = 1'b1;
    repeat (18) send_cmd(CMD_REGISTER, 4'($urandom), 1'($urandom), pick_delay(), 1'($urandom));
    send_cmd(CMD_TICK, 4'd0);
    send_cmd(CMD_POLL, 4'd1);
    wait_all_results();

    while (items_sent < ITEM_TARGET) begin
      run_episode();
      if ($urandom_range(0, 3) == 0) wait_all_results();
    end

    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
